// ===== hw/rtl/cpwm_pkg.sv =====
// Shared types and constants for the center-aligned PWM channel.
package cpwm_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_PERIOD     = 2'd0;
	localparam logic [1:0] REG_RISE_DELAY = 2'd1;
	localparam logic [1:0] REG_FALL_DELAY = 2'd2;
	localparam logic [1:0] REG_IRQ_ENABLE = 2'd3;

	// Reset values (truncated to the configured widths where used)
	localparam int PERIOD_RESET  = 2500;
	localparam int COMPARE_RESET = PERIOD_RESET / 2;
	localparam int DELAY_RESET   = 200;

	// Q1.15 duty scaling
	localparam int DUTY_BITS  = 16;
	localparam int DUTY_FRAC  = 15;
	localparam int COUNT_OUT_BITS = 16;

	// Per-tick status from the carrier to the output stage
	typedef struct packed {
		logic raw_d;   // raw level after this tick's compare
		logic irq;     // period-start pulse (already gated by enable)
	} carrier_stat_t;

endpackage

// ===== hw/rtl/cpwm_if.sv =====
// Valid/ready channel interfaces for command items and result items.
interface cpwm_cmd_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] duty;

	modport source (output valid, output action, output duty, input ready);
	modport sink   (input valid, input action, input duty, output ready);
endinterface

interface cpwm_rsp_if;
	logic        valid;
	logic        ready;
	logic        high_side;
	logic        low_side;
	logic        period_irq;
	logic [15:0] count_value;

	modport source (output valid, output high_side, output low_side, output period_irq,
		output count_value, input ready);
	modport sink   (input valid, input high_side, input low_side, input period_irq,
		input count_value, output ready);
endinterface

// ===== hw/rtl/cpwm_edge_delay.sv =====
// Rising-edge delay: a 0-to-1 edge of level passes after delay ticks, 1-to-0 at once.
module cpwm_edge_delay #(
	parameter int  DELAY_BITS = 14,
	parameter bit  OUT_RESET  = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  level,
	input  logic [DELAY_BITS-1:0] delay,
	output logic                  held_q,
	output logic                  held_d
);

	logic [DELAY_BITS-1:0] timer_q;
	logic [DELAY_BITS-1:0] timer_d;

	always_comb begin
		held_d  = held_q;
		timer_d = timer_q;
		if (!level) begin
			held_d  = 1'b0;
			timer_d = '0;
		end else if (!held_q) begin
			if (timer_q >= delay) begin
				held_d = 1'b1;
			end else begin
				timer_d = timer_q + DELAY_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= OUT_RESET;
			timer_q <= '0;
		end else if (step) begin
			held_q  <= held_d;
			timer_q <= timer_d;
		end
	end

endmodule

// ===== hw/rtl/cpwm_carrier.sv =====
// Up-down carrier counter, shadow/active compare and raw PWM level.
module cpwm_carrier #(
	parameter int COUNTER_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick,
	input  logic                          duty_wr,
	input  logic [cpwm_pkg::DUTY_BITS-1:0] duty,
	input  logic [COUNTER_BITS-1:0]       period,
	input  logic                          irq_enable,
	output logic [COUNTER_BITS-1:0]       count_q,
	output cpwm_pkg::carrier_stat_t       stat
);

	localparam int PROD_BITS = COUNTER_BITS + cpwm_pkg::DUTY_BITS;

	logic                    down_q;
	logic [COUNTER_BITS-1:0] active_q;
	logic [COUNTER_BITS-1:0] shadow_q;
	logic                    raw_q;

	logic [PROD_BITS-1:0]    prod;
	logic [COUNTER_BITS:0]   scaled;
	logic [COUNTER_BITS-1:0] cmp_d;
	logic                    at_zero;
	logic                    down_d;
	logic [COUNTER_BITS-1:0] active_eff;
	logic                    raw_d;
	logic [COUNTER_BITS-1:0] count_d;

	// Duty write: floor(duty * period / 2^15), clamped to the period
	assign prod   = PROD_BITS'(duty) * PROD_BITS'(period);
	assign scaled = prod[PROD_BITS-1:cpwm_pkg::DUTY_FRAC];
	assign cmp_d  = (scaled > {1'b0, period}) ? period : scaled[COUNTER_BITS-1:0];

	// Tick
	assign at_zero    = (count_q == '0);
	assign active_eff = at_zero ? shadow_q : active_q;
	assign down_d     = (count_q >= period) ? 1'b1 : (at_zero ? 1'b0 : down_q);
	assign raw_d      = (count_q == active_eff) ? down_d : raw_q;

	always_comb begin
		if (down_d) begin
			count_d = at_zero ? count_q : count_q - COUNTER_BITS'(1);
		end else begin
			count_d = count_q + COUNTER_BITS'(1);
		end
	end

	assign stat.raw_d = raw_d;
	assign stat.irq   = at_zero & irq_enable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			down_q   <= 1'b0;
			active_q <= COUNTER_BITS'(cpwm_pkg::COMPARE_RESET);
			shadow_q <= COUNTER_BITS'(cpwm_pkg::COMPARE_RESET);
			raw_q    <= 1'b0;
		end else begin
			if (duty_wr) begin
				shadow_q <= cmp_d;
			end
			if (tick) begin
				count_q  <= count_d;
				down_q   <= down_d;
				active_q <= active_eff;
				raw_q    <= raw_d;
			end
		end
	end

endmodule

// ===== hw/rtl/center_aligned_pwm_dead_band_top.sv =====
// Top level of the center-aligned PWM channel with complementary dead-band outputs.
// Each command item gives exactly one result item. A tick item (action 0) advances
// the up-down carrier by one step and returns the gate drives, the period-start
// interrupt and the counter value seen on that tick; a duty item (action 1) loads
// the Q1.15 duty into the shadow compare, which the carrier takes over at its next
// zero, and returns the present outputs with the interrupt low. The block takes
// one item per clock cycle while results are taken; an item waits in the input register
// and moves into the result register when that register is empty or being drained, and
// its result is then offered there. The rate is set by the carrier and dead-band state,
// which is read and written once per item. Configuration registers (period, rise delay,
// fall delay, interrupt enable) are written through cfg_we / cfg_index / cfg_data and
// act at once; write them only while no item is in flight.
module center_aligned_pwm_dead_band_top #(
	parameter int COUNTER_BITS = 16,
	parameter int DELAY_BITS   = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [(COUNTER_BITS > DELAY_BITS ? COUNTER_BITS : DELAY_BITS)-1:0] cfg_data,
	cpwm_cmd_if.sink             cmd,
	cpwm_rsp_if.source           rsp
);

	// ---------------- configuration registers ----------------
	logic [COUNTER_BITS-1:0] period_q;
	logic [DELAY_BITS-1:0]   rise_delay_q;
	logic [DELAY_BITS-1:0]   fall_delay_q;
	logic                    irq_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= COUNTER_BITS'(cpwm_pkg::PERIOD_RESET);
			rise_delay_q <= DELAY_BITS'(cpwm_pkg::DELAY_RESET);
			fall_delay_q <= DELAY_BITS'(cpwm_pkg::DELAY_RESET);
			irq_enable_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				cpwm_pkg::REG_PERIOD:     period_q     <= cfg_data[COUNTER_BITS-1:0];
				cpwm_pkg::REG_RISE_DELAY: rise_delay_q <= cfg_data[DELAY_BITS-1:0];
				cpwm_pkg::REG_FALL_DELAY: fall_delay_q <= cfg_data[DELAY_BITS-1:0];
				cpwm_pkg::REG_IRQ_ENABLE: irq_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	logic                              valid_s1;
	logic                              action_s1;
	logic [cpwm_pkg::DUTY_BITS-1:0]    duty_s1;
	logic                              out_valid_q;
	logic                              advance;

	// The stage-1 item moves into the result register whenever that register is
	// empty or being drained this cycle; a new item may enter behind it.
	assign advance   = valid_s1 & (~out_valid_q | rsp.ready);
	assign cmd.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready & cmd.valid) begin
			action_s1 <= cmd.action;
			duty_s1   <= cmd.duty;
		end
	end

	// ---------------- carrier and dead band ----------------
	logic                    tick;
	logic                    duty_wr;
	logic [COUNTER_BITS-1:0] count_q;
	cpwm_pkg::carrier_stat_t stat;
	logic                    high_q;
	logic                    high_d;
	logic                    low_q;
	logic                    low_d;

	assign tick    = advance & ~action_s1;
	assign duty_wr = advance & action_s1;

	cpwm_carrier #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_carrier (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.duty_wr    (duty_wr),
		.duty       (duty_s1),
		.period     (period_q),
		.irq_enable (irq_enable_q),
		.count_q    (count_q),
		.stat       (stat)
	);

	// High side: raw level with its rising edges held back by rise_delay.
	cpwm_edge_delay #(
		.DELAY_BITS (DELAY_BITS),
		.OUT_RESET  (1'b0)
	) u_high_delay (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (tick),
		.level  (stat.raw_d),
		.delay  (rise_delay_q),
		.held_q (high_q),
		.held_d (high_d)
	);

	// Low side: inverted raw level with its rising edges held back by fall_delay.
	// It starts high out of reset, since the raw level starts low.
	cpwm_edge_delay #(
		.DELAY_BITS (DELAY_BITS),
		.OUT_RESET  (1'b1)
	) u_low_delay (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (tick),
		.level  (~stat.raw_d),
		.delay  (fall_delay_q),
		.held_q (low_q),
		.held_d (low_d)
	);

	// ---------------- result register ----------------
	// Ticks report the drives after this tick's update; duty writes report the
	// present drives. The counter shown is the value before it advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (~out_valid_q | rsp.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	logic high_side_q;
	logic low_side_q;
	logic period_irq_q;
	logic [cpwm_pkg::COUNT_OUT_BITS-1:0] count_value_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			high_side_q   <= action_s1 ? high_q : high_d;
			low_side_q    <= action_s1 ? low_q : low_d;
			period_irq_q  <= action_s1 ? 1'b0 : stat.irq;
			count_value_q <= cpwm_pkg::COUNT_OUT_BITS'(count_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.high_side   = high_side_q;
	assign rsp.low_side    = low_side_q;
	assign rsp.period_irq  = period_irq_q;
	assign rsp.count_value = count_value_q;

endmodule
